FILE: design/quaternion_nlerp_assert.svh
// ----------------------------------------------------------------------------
// Quaternion nlerp assertion macros
// Concurrent assertion forms used by the quaternion nlerp queue.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_NLERP_ASSERT_SVH
`define QUATERNION_NLERP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define QNL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define QNL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/qnl_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion nlerp package
// Formats, pipeline sizes, the queue word type and the output saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qnl_pkg;

	// Component format Q2.14 and weight format Q1.15.
	localparam int CB             = 16;
	localparam int WF             = 15;
	localparam int BL_W           = 19;
	localparam int MAG_W          = 18;
	localparam int SQ_W           = 38;
	localparam int LEN_FRAC       = 26;
	localparam int SQ_SHIFT       = 12;
	localparam int RAD_W          = 64;
	localparam int ROOT_STEPS     = 32;
	localparam int LEN_W          = 32;
	localparam int QUO_BITS       = 17;
	localparam int NUM_W          = 49;
	localparam int ZERO_LEN_LIMIT = 671;
	localparam int FRONT_STAGES   = 5;
	localparam int QUEUE_DEPTH    = 8;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

	// One word moved from the front part to the back part.
	typedef struct packed {
		logic [3:0][BL_W-1:0] blend;
		logic [SQ_W-1:0]      sumsq;
	} qnl_item_t;

	typedef struct packed {
		logic      valid;
		qnl_item_t item;
	} qnl_word_t;

	// Saturate a signed value to the component range.
	function automatic logic [CB-1:0] sat_comp(input logic signed [BL_W-1:0] x);
		logic signed [BL_W-1:0] hi;
		logic signed [BL_W-1:0] lo;
		hi = BL_W'((1 <<< (CB - 1)) - 1);
		lo = -BL_W'(1 <<< (CB - 1));
		if (x > hi)
			return hi[CB-1:0];
		else if (x < lo)
			return lo[CB-1:0];
		else
			return x[CB-1:0];
	endfunction

endpackage

FILE: design/qnl_front.sv
// ----------------------------------------------------------------------------
// Quaternion nlerp front part
// Forms the dot product sign, the weighted blend and the squared length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qnl_front import qnl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [3:0][CB-1:0]   a,
	input  logic [3:0][CB-1:0]   b,
	input  logic [15:0]          t,
	output qnl_word_t            push
);

	logic                     valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic signed [2*CB-1:0]   ab_s1 [4];
	logic signed [33:0]       pa_s1 [4];
	logic signed [32:0]       pb_s1 [4];
	logic signed [33:0]       pa_s2 [4];
	logic signed [32:0]       pb_s2 [4];
	logic                     neg_s2;
	logic signed [BL_W-1:0]   blend_s3 [4];
	logic signed [BL_W-1:0]   blend_s4 [4];
	logic [2*MAG_W-1:0]       sq_s4 [4];
	logic [3:0][BL_W-1:0]     blend_s5;
	logic [SQ_W-1:0]          sumsq_s5;
	logic signed [17:0]       t2;
	logic signed [16:0]       tx;
	logic signed [33:0]       dot;

	// Valid bits of the front pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Weight on a is one minus t, weight on b is t before the sign choice.
	assign tx = $signed({1'b0, t});
	assign t2 = $signed(18'd32768) - $signed({2'b00, t});

	// Stage 1: all products taken straight from the ports.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			ab_s1[i] <= $signed(a[i]) * $signed(b[i]);
			pa_s1[i] <= t2 * $signed(a[i]);
			pb_s1[i] <= tx * $signed(b[i]);
		end
	end

	// Stage 2: sign of the exact dot product picks the shorter path.
	always_comb begin
		dot = 34'(ab_s1[0]) + 34'(ab_s1[1]) + 34'(ab_s1[2]) + 34'(ab_s1[3]);
	end

	always_ff @(posedge clk) begin
		neg_s2 <= dot[33];
		for (int i = 0; i < 4; i++) begin
			pa_s2[i] <= pa_s1[i];
			pb_s2[i] <= pb_s1[i];
		end
	end

	// Stage 3: blend and round to the component format, ties away from zero.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			logic signed [34:0] sum;
			logic [34:0]        mag;
			logic [34:0]        rnd;
			sum = 35'(pa_s2[i]) + (neg_s2 ? -35'(pb_s2[i]) : 35'(pb_s2[i]));
			mag = sum[34] ? 35'(-sum) : 35'(sum);
			rnd = (mag + 35'(1 << (WF - 1))) >> WF;
			blend_s3[i] <= sum[34] ? -$signed(rnd[BL_W-1:0]) : $signed(rnd[BL_W-1:0]);
		end
	end

	// Stage 4: squares of the blended components.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			logic [BL_W-1:0] m;
			m = blend_s3[i][BL_W-1] ? BL_W'(-blend_s3[i]) : BL_W'(blend_s3[i]);
			sq_s4[i]    <= m[MAG_W-1:0] * m[MAG_W-1:0];
			blend_s4[i] <= blend_s3[i];
		end
	end

	// Stage 5: squared length.
	always_ff @(posedge clk) begin
		sumsq_s5 <= SQ_W'(sq_s4[0]) + SQ_W'(sq_s4[1]) + SQ_W'(sq_s4[2]) + SQ_W'(sq_s4[3]);
		for (int i = 0; i < 4; i++)
			blend_s5[i] <= blend_s4[i];
	end

	assign push.valid      = valid_s5;
	assign push.item.blend = blend_s5;
	assign push.item.sumsq = sumsq_s5;

endmodule

FILE: design/qnl_queue.sv
// ----------------------------------------------------------------------------
// Quaternion nlerp queue
// Short queue between the front and back parts, with credit-based busy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qnl_queue import qnl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  qnl_word_t push,
	output logic      busy,
	output qnl_word_t pop
);

	`include "quaternion_nlerp_assert.svh"

	qnl_item_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]    count_q;
	logic               rd_en;
	logic               pop_valid_q;
	qnl_item_t          pop_item_q;
	logic               q_full;
	logic               q_over;
	logic               q_one;

	assign rd_en = (count_q != '0);

	// Fill level flags used by the checks below.
	assign q_full = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign q_over = (count_q > (QPTR_W + 1)'(QUEUE_DEPTH));
	assign q_one  = (count_q == (QPTR_W + 1)'(1));

	// Hold off new words while the queue cannot absorb the front in flight.
	assign busy = (count_q >= (QPTR_W + 1)'(QUEUE_DEPTH - FRONT_STAGES));

	// Storage write.
	always_ff @(posedge clk) begin
		if (push.valid)
			mem_q[wr_ptr_q] <= push.item;
	end

	// Registered read toward the back part.
	always_ff @(posedge clk) begin
		if (rd_en)
			pop_item_q <= mem_q[rd_ptr_q];
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			pop_valid_q <= 1'b0;
		end else begin
			pop_valid_q <= rd_en;
			if (push.valid)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (QPTR_W + 1)'(push.valid) - (QPTR_W + 1)'(rd_en);
		end
	end

	assign pop.valid = pop_valid_q;
	assign pop.item  = pop_item_q;

	`QNL_ASSERT(q_no_overflow, clk, arst_n, !(push.valid && !rd_en && q_full), "queue write while full")
	`QNL_ASSERT(q_count_bound, clk, arst_n, !q_over, "queue count beyond depth")
	`QNL_ASSERT_NEXT(q_drain_one, clk, arst_n, q_one && !push.valid, !rd_en && pop.valid, "single word not drained")

endmodule

FILE: design/qnl_back.sv
// ----------------------------------------------------------------------------
// Quaternion nlerp back part
// Bit-serial pipelined square root, restoring divide and output saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qnl_back import qnl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  qnl_word_t          pop,
	output logic               done,
	output logic [3:0][CB-1:0] result,
	output logic               zero_length
);

	// Square root pipeline, one result bit per stage.
	logic                 r_vld_q [ROOT_STEPS+1];
	logic [RAD_W-1:0]     r_rem_q [ROOT_STEPS+1];
	logic [RAD_W-1:0]     r_root_q [ROOT_STEPS+1];
	logic [3:0][BL_W-1:0] r_bl_q [ROOT_STEPS+1];

	assign r_vld_q[0]  = pop.valid;
	assign r_rem_q[0]  = RAD_W'({pop.item.sumsq, {(2 * SQ_SHIFT){1'b0}}});
	assign r_root_q[0] = '0;
	assign r_bl_q[0]   = pop.item.blend;

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		localparam int SH = 2 * (ROOT_STEPS - 1 - k);
		logic [RAD_W-1:0] trial;
		assign trial = r_root_q[k] + (RAD_W'(1) << SH);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				r_vld_q[k+1] <= 1'b0;
			else
				r_vld_q[k+1] <= r_vld_q[k];
		end

		always_ff @(posedge clk) begin
			r_bl_q[k+1] <= r_bl_q[k];
			if (r_rem_q[k] >= trial) begin
				r_rem_q[k+1]  <= r_rem_q[k] - trial;
				r_root_q[k+1] <= (r_root_q[k] >> 1) + (RAD_W'(1) << SH);
			end else begin
				r_rem_q[k+1]  <= r_rem_q[k];
				r_root_q[k+1] <= r_root_q[k] >> 1;
			end
		end
	end

	// Divide setup: rounded numerator, overflow check and short-length flag.
	logic [LEN_W-1:0] len;
	assign len = r_root_q[ROOT_STEPS][LEN_W-1:0];

	logic                 d_vld_q [QUO_BITS+1];
	logic [NUM_W-1:0]     d_rem_q [QUO_BITS+1][4];
	logic [QUO_BITS-1:0]  d_quo_q [QUO_BITS+1][4];
	logic [3:0]           d_ovf_q [QUO_BITS+1];
	logic                 d_short_q [QUO_BITS+1];
	logic [LEN_W-1:0]     d_len_q [QUO_BITS+1];
	logic [3:0][BL_W-1:0] d_bl_q [QUO_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			d_vld_q[0] <= 1'b0;
		else
			d_vld_q[0] <= r_vld_q[ROOT_STEPS];
	end

	always_ff @(posedge clk) begin
		d_short_q[0] <= (len <= LEN_W'(ZERO_LEN_LIMIT));
		d_len_q[0]   <= len;
		d_bl_q[0]    <= r_bl_q[ROOT_STEPS];
		for (int i = 0; i < 4; i++) begin
			logic signed [BL_W-1:0] v;
			logic [BL_W-1:0]        m;
			logic [NUM_W-1:0]       num;
			v   = $signed(r_bl_q[ROOT_STEPS][i]);
			m   = v[BL_W-1] ? BL_W'(-v) : BL_W'(v);
			num = (NUM_W'(m) << LEN_FRAC) + NUM_W'(len >> 1);
			d_rem_q[0][i] <= num;
			d_quo_q[0][i] <= '0;
			d_ovf_q[0][i] <= (num >= (NUM_W'(len) << QUO_BITS));
		end
	end

	// Restoring divide, one quotient bit per stage.
	for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
		localparam int SH = QUO_BITS - 1 - j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				d_vld_q[j+1] <= 1'b0;
			else
				d_vld_q[j+1] <= d_vld_q[j];
		end

		always_ff @(posedge clk) begin
			d_short_q[j+1] <= d_short_q[j];
			d_len_q[j+1]   <= d_len_q[j];
			d_bl_q[j+1]    <= d_bl_q[j];
			d_ovf_q[j+1]   <= d_ovf_q[j];
			for (int i = 0; i < 4; i++) begin
				logic [NUM_W-1:0] dv;
				dv = NUM_W'(d_len_q[j]) << SH;
				if (d_rem_q[j][i] >= dv) begin
					d_rem_q[j+1][i] <= d_rem_q[j][i] - dv;
					d_quo_q[j+1][i] <= {d_quo_q[j][i][QUO_BITS-2:0], 1'b1};
				end else begin
					d_rem_q[j+1][i] <= d_rem_q[j][i];
					d_quo_q[j+1][i] <= {d_quo_q[j][i][QUO_BITS-2:0], 1'b0};
				end
			end
		end
	end

	// Output stage: clamp, restore sign and saturate; for a short length the blend itself is saturated instead.
	logic               done_q;
	logic [3:0][CB-1:0] result_q;
	logic               zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= d_vld_q[QUO_BITS];
	end

	always_ff @(posedge clk) begin
		zero_q <= d_short_q[QUO_BITS];
		for (int i = 0; i < 4; i++) begin
			logic signed [BL_W-1:0] v;
			logic [BL_W-1:0]        qc;
			logic signed [BL_W-1:0] sq;
			v = $signed(d_bl_q[QUO_BITS][i]);
			if (d_ovf_q[QUO_BITS][i] || (BL_W'(d_quo_q[QUO_BITS][i]) > BL_W'(1 << CB)))
				qc = BL_W'(1 << CB);
			else
				qc = BL_W'(d_quo_q[QUO_BITS][i]);
			sq = v[BL_W-1] ? -$signed(qc) : $signed(qc);
			if (d_short_q[QUO_BITS])
				result_q[i] <= sat_comp(v);
			else
				result_q[i] <= sat_comp(sq);
		end
	end

	assign done        = done_q;
	assign result      = result_q;
	assign zero_length = zero_q;

endmodule

FILE: design/quaternion_nlerp.sv
// ----------------------------------------------------------------------------
// Quaternion nlerp top level
// Normalized linear interpolation of two Q2.14 quaternions by a Q1.15 weight.
// ----------------------------------------------------------------------------
// Usage:
//   A word (a, b, blend_weight) is taken at a rising edge with start high and
//   busy low. busy is a credit signal from the internal queue and stays low
//   in normal streaming, so one word can enter every cycle.
//   Each word gives one result: done is high for exactly one cycle with
//   out_x..out_w and zero_length valid in that same cycle. The receiver
//   cannot stall; results simply appear in input order.
//   The path runs through 5 front stages (products, dot sign, blend, squares,
//   length sum), the queue with its registered read, 32 square root stages (one root
//   bit each), 1 divide setup stage, 17 divide stages (one quotient bit each)
//   and 1 output register. Throughput is one word per cycle while busy is low,
//   set by the fully pipelined root and divide.
//   Reset (arst_n low) clears all valid bits and the queue; words in flight
//   are dropped and done stays low until new words arrive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_nlerp import qnl_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [CB-1:0] a_x,
	input  logic [CB-1:0] a_y,
	input  logic [CB-1:0] a_z,
	input  logic [CB-1:0] a_w,
	input  logic [CB-1:0] b_x,
	input  logic [CB-1:0] b_y,
	input  logic [CB-1:0] b_z,
	input  logic [CB-1:0] b_w,
	input  logic [15:0]   blend_weight,
	output logic          done,
	output logic [CB-1:0] out_x,
	output logic [CB-1:0] out_y,
	output logic [CB-1:0] out_z,
	output logic [CB-1:0] out_w,
	output logic          zero_length
);

	logic               accept;
	qnl_word_t          push;
	qnl_word_t          pop;
	logic [3:0][CB-1:0] result;

	// Input handshake.
	assign accept = start && !busy;

	qnl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.a      ({a_w, a_z, a_y, a_x}),
		.b      ({b_w, b_z, b_y, b_x}),
		.t      (blend_weight),
		.push   (push)
	);

	qnl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.busy   (busy),
		.pop    (pop)
	);

	qnl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop         (pop),
		.done        (done),
		.result      (result),
		.zero_length (zero_length)
	);

	// Component outputs.
	assign out_x = result[0];
	assign out_y = result[1];
	assign out_z = result[2];
	assign out_w = result[3];

endmodule
